// ===== rtl/bcc_pkg.sv =====
// ---------------------------------------------------------------------------
// bcc_pkg
// Shared types and constants of the button click classifier: phase codes,
// event codes, register indexes, reset values and the structs between stages.
// ---------------------------------------------------------------------------
package bcc_pkg;

   localparam int unsigned TimeWidth  = 32;
   localparam int unsigned LimitWidth = 16;
   localparam int unsigned IndexWidth = 2;

   // Configuration register indexes
   localparam logic [IndexWidth-1:0] CSR_DEBOUNCE     = 2'd0;
   localparam logic [IndexWidth-1:0] CSR_LONG_PRESS   = 2'd1;
   localparam logic [IndexWidth-1:0] CSR_DOUBLE_CLICK = 2'd2;

   // Register reset values
   localparam logic [LimitWidth-1:0] DebounceReset    = 16'd10;
   localparam logic [LimitWidth-1:0] LongPressReset   = 16'd2000;
   localparam logic [LimitWidth-1:0] DoubleClickReset = 16'd500;

   typedef enum logic [1:0] {
      EV_NONE   = 2'd0,
      EV_SINGLE = 2'd1,
      EV_DOUBLE = 2'd2,
      EV_LONG   = 2'd3
   } event_type;

   typedef enum logic [4:0] {
      PH_IDLE      = 5'b00001,
      PH_PENDING   = 5'b00010,
      PH_HELD      = 5'b00100,
      PH_HELD_LONG = 5'b01000,
      PH_RELEASED  = 5'b10000
   } phase_type;

   typedef struct packed {
      logic                 button_down;
      logic [TimeWidth-1:0] now_ms;
   } item_type;

   // Registered request as seen by the classifier
   typedef struct packed {
      logic     fire;
      item_type item;
   } stage_type;

   typedef struct packed {
      logic [LimitWidth-1:0] debounce_ms;
      logic [LimitWidth-1:0] long_press_ms;
      logic [LimitWidth-1:0] double_click_ms;
   } cfg_type;

endpackage

// ===== rtl/button_click_classifier.sv =====
// ---------------------------------------------------------------------------
// button_click_classifier
// Debounces a sampled push button and reports single clicks, double clicks
// and long presses from millisecond time stamps.
// ---------------------------------------------------------------------------
// One request in, one event out (none, single, double or long press). A
// request waits in the input register, then the phase machine steps and its
// event lands in the result register; a new request is taken every cycle
// while the result register drains. The phase, time mark and pending-click
// flag live beside the single elapsed-time comparator that sets this
// per-request step. The user must write limits through the csr port only
// while no request is in flight (not enforced); indexes above two are ignored.
module button_click_classifier (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_button_down,
   input  logic [31:0] req_now_ms,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [1:0]  rsp_event_code,
   input  logic        csr_write_en,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);
   import bcc_pkg::*;

   cfg_type   cfg_ff;
   item_type  req_item;
   stage_type stage;
   event_type event_code;
   logic      out_free;

   // Hold the configuration limits
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ms     <= DebounceReset;
         cfg_ff.long_press_ms   <= LongPressReset;
         cfg_ff.double_click_ms <= DoubleClickReset;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_DEBOUNCE:     cfg_ff.debounce_ms     <= csr_wdata;
            CSR_LONG_PRESS:   cfg_ff.long_press_ms   <= csr_wdata;
            CSR_DOUBLE_CLICK: cfg_ff.double_click_ms <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign req_item.button_down = req_button_down;
   assign req_item.now_ms      = req_now_ms;

   bcc_in_stage u_in_stage (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .out_free  (out_free),
      .stage     (stage)
   );

   bcc_fsm u_fsm (
      .clock      (clock),
      .reset      (reset),
      .stage      (stage),
      .cfg        (cfg_ff),
      .event_code (event_code)
   );

   bcc_out_stage u_out_stage (
      .clock          (clock),
      .reset          (reset),
      .load           (stage.fire),
      .event_code     (event_code),
      .out_free       (out_free),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_event_code (rsp_event_code)
   );

endmodule

// ===== rtl/bcc_in_stage.sv =====
// ---------------------------------------------------------------------------
// bcc_in_stage
// Input register: holds one accepted request until the result register can
// take its event.
// ---------------------------------------------------------------------------
module bcc_in_stage (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  bcc_pkg::item_type req_item,
   input  logic              out_free,
   output bcc_pkg::stage_type stage
);
   import bcc_pkg::*;

   logic     valid_ff;
   logic     valid_in;
   item_type item_ff;
   logic     fire;

   // Advance the held request whenever the result slot is free
   assign fire      = valid_ff & out_free;
   assign req_ready = ~valid_ff | fire;
   assign valid_in  = (req_valid & req_ready) | (valid_ff & ~fire);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Capture payload on acceptance
   always_ff @(posedge clock) begin
      if (req_valid & req_ready) begin
         item_ff <= req_item;
      end
   end

   assign stage.fire = fire;
   assign stage.item = item_ff;

endmodule

// ===== rtl/bcc_fsm.sv =====
// ---------------------------------------------------------------------------
// bcc_fsm
// Click phase machine: time mark, pending-click flag and one shared
// wrap-safe elapsed-time compare.
// ---------------------------------------------------------------------------
module bcc_fsm (
   input  logic                clock,
   input  logic                reset,
   input  bcc_pkg::stage_type  stage,
   input  bcc_pkg::cfg_type    cfg,
   output bcc_pkg::event_type  event_code
);
   import bcc_pkg::*;

   phase_type            phase_ff;
   phase_type            phase_in;
   logic [TimeWidth-1:0] mark_ff;
   logic [TimeWidth-1:0] mark_in;
   logic                 pending_ff;
   logic                 pending_in;

   logic [LimitWidth-1:0] limit;
   logic [TimeWidth-1:0]  elapsed;
   logic                  timed_out;
   logic                  down;
   logic [TimeWidth-1:0]  now;
   event_type             ev;

   assign down = stage.item.button_down;
   assign now  = stage.item.now_ms;

   // Pick the limit that the current phase checks
   always_comb begin
      unique case (phase_ff)
         PH_PENDING:  limit = cfg.debounce_ms;
         PH_HELD:     limit = cfg.long_press_ms;
         PH_RELEASED: limit = cfg.double_click_ms;
         default:     limit = cfg.debounce_ms;
      endcase
   end

   assign elapsed   = now - mark_ff;
   assign timed_out = elapsed >= {{(TimeWidth-LimitWidth){1'b0}}, limit};

   // Step the phase machine
   always_comb begin
      phase_in   = phase_ff;
      mark_in    = mark_ff;
      pending_in = pending_ff;
      ev         = EV_NONE;
      unique case (phase_ff)
         PH_PENDING: begin
            if (!down) begin
               phase_in = PH_IDLE;
            end else if (timed_out) begin
               phase_in = PH_HELD;
            end
         end
         PH_HELD: begin
            if (!down) begin
               if (pending_ff) begin
                  pending_in = 1'b0;
                  ev         = EV_DOUBLE;
                  phase_in   = PH_IDLE;
               end else begin
                  mark_in  = now;
                  phase_in = PH_RELEASED;
               end
            end else if (timed_out) begin
               ev       = EV_LONG;
               phase_in = PH_HELD_LONG;
            end
         end
         PH_HELD_LONG: begin
            if (!down) begin
               phase_in = PH_IDLE;
            end
         end
         PH_RELEASED: begin
            // A second press wins over the window timeout
            if (down) begin
               pending_in = 1'b1;
               mark_in    = now;
               phase_in   = PH_PENDING;
            end else if (timed_out) begin
               pending_in = 1'b0;
               ev         = EV_SINGLE;
               phase_in   = PH_IDLE;
            end
         end
         default: begin
            if (down) begin
               mark_in  = now;
               phase_in = PH_PENDING;
            end else begin
               phase_in = PH_IDLE;
            end
         end
      endcase
   end

   assign event_code = ev;

   // Update state only when a request passes through
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         mark_ff    <= '0;
         pending_ff <= 1'b0;
      end else if (stage.fire) begin
         phase_ff   <= phase_in;
         mark_ff    <= mark_in;
         pending_ff <= pending_in;
      end
   end

endmodule

// ===== rtl/bcc_out_stage.sv =====
// ---------------------------------------------------------------------------
// bcc_out_stage
// Result register: holds one event until the consumer takes it.
// ---------------------------------------------------------------------------
module bcc_out_stage (
   input  logic               clock,
   input  logic               reset,
   input  logic               load,
   input  bcc_pkg::event_type event_code,
   output logic               out_free,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [1:0]         rsp_event_code
);
   import bcc_pkg::*;

   logic      valid_ff;
   logic      valid_in;
   event_type code_ff;

   // Slot is free when empty or being drained this cycle
   assign out_free = ~valid_ff | rsp_ready;
   assign valid_in = load | (valid_ff & ~rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         code_ff <= event_code;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_event_code = code_ff;

endmodule

// ===== rtl/bcc_checker.sv =====
// ---------------------------------------------------------------------------
// bcc_checker
// Port-level checks of the click classifier, bound to the top level.
// ---------------------------------------------------------------------------
module bcc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_event_code
);
   logic [1:0] inflight_ff;
   logic [1:0] inflight_in;
   logic       req_take;
   logic       rsp_take;

   assign req_take = req_valid & req_ready;
   assign rsp_take = rsp_valid & rsp_ready;

   // Track requests accepted but not yet answered
   always_comb begin
      inflight_in = inflight_ff;
      if (req_take & ~rsp_take) begin
         inflight_in = inflight_ff + 2'd1;
      end else if (rsp_take & ~req_take) begin
         inflight_in = inflight_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inflight_ff <= 2'd0;
      end else begin
         inflight_ff <= inflight_in;
      end
   end

   // A stalled result holds its event
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_event_code))
      else $error("stalled result changed");

   // No result without a request behind it
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> inflight_ff != 2'd0)
      else $error("result without request");

   // At most two requests are held inside
   assert property (@(posedge clock) disable iff (reset)
      inflight_ff != 2'd3)
      else $error("too many requests held");

   // An empty result slot never blocks new requests
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("request refused with result slot empty");

endmodule

bind button_click_classifier bcc_checker u_bcc_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_event_code (rsp_event_code)
);
